// ===== rtl/core/tlbat_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbat_pkg
// Shared types and constants of the TLB address translation unit: entry field
// positions, result status codes, register indexes and the control structs.
// ----------------------------------------------------------------------------
package tlbat_pkg;

  // Fields of an entry hi word.
  localparam int HI_VALID_BIT = 0;
  localparam int HI_ASID_LSB  = 1;
  localparam int HI_ASID_MSB  = 10;
  localparam int ASID_W       = HI_ASID_MSB - HI_ASID_LSB + 1;

  // Permission bits of an entry lo word.
  localparam int LO_W_BIT = 3;
  localparam int LO_U_BIT = 2;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 4;
  localparam int CFG_W  = 10;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAULT = 2'd1,
    ST_MISS  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_VM_ENABLE    = 2'd0,
    CFG_PRIVILEGED   = 2'd1,
    CFG_CURRENT_ASID = 2'd2
  } cfg_idx_t;

  // Source of the result word loaded into the result register.
  typedef enum logic [1:0] {
    RES_WRITE = 2'd0,
    RES_PASS  = 2'd1,
    RES_HIT   = 2'd2,
    RES_MISS  = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     capture;
    logic     ram_we;
    logic     issue;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic vm_enable;
    logic pend;
    logic hit;
    logic last;
    logic cnt_end;
  } dp_stat_t;

endpackage

// ===== rtl/core/tlb_address_translation_unit.sv =====
// ----------------------------------------------------------------------------
// tlb_address_translation_unit
// Fully associative TLB with ASID match, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Writes and pass-through translations need no scan; the time to a hit or a
// miss is set by the one-entry-per-cycle scan of the entry RAM. A new item
// is accepted only after the previous result has moved to the output register.
// Reset (synchronous, rst_n low) clears all entry valid bits at once,
// translation off, supervisor mode on, ASID zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
//
// Structure: tlbat_ctrl is the sequencer and tlbat_dp holds the configuration
// registers, the entry RAM with its valid bits, the scan counter, the match
// and permission logic and the result and output registers.
//
// A translate beat with translation on starts a scan from slot 0 upward. Each
// cycle one RAM read is issued and the entry read in the previous cycle is
// checked, so the first matching slot (lowest index) ends the scan. A write
// beat stores the hi and lo words in the cycle it is accepted; slot indexes at
// or above TLB_DEPTH are dropped but still answer ok.
//
// The result is parked in a result register and moved into the output
// register as soon as that is free, so a new beat is accepted while the
// previous result still waits on the output side.
//
// The configuration port is always ready. Index 0 is vm_enable, 1 privileged,
// 2 current_asid; index 3 is ignored.
module tlb_address_translation_unit #(
  parameter int TLB_DEPTH = 16,
  parameter int PAGE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [tlbat_pkg::WORD_W-1:0]  in_vaddr,
  input  logic                          in_is_write,
  input  logic                          in_is_execute,
  input  logic [tlbat_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [tlbat_pkg::WORD_W-1:0]  in_entry_hi,
  input  logic [tlbat_pkg::WORD_W-1:0]  in_entry_lo,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [tlbat_pkg::WORD_W-1:0]  out_paddr,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [tlbat_pkg::CFG_W-1:0]   cfg_data
);

  tlbat_pkg::ctrl_cmd_t cmd;
  tlbat_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  tlbat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tlbat_dp #(
    .TLB_DEPTH (TLB_DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_vaddr       (in_vaddr),
    .in_is_write    (in_is_write),
    .in_is_execute  (in_is_execute),
    .in_entry_index (in_entry_index),
    .in_entry_hi    (in_entry_hi),
    .in_entry_lo    (in_entry_lo),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_status     (out_status),
    .out_paddr      (out_paddr)
  );

  // Faults and misses never carry an address.
  a_err_zero_paddr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != tlbat_pkg::ST_OK)) |-> (out_paddr == '0))
    else $error("non-ok result beat carries a nonzero address");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("result beat carries an undefined status code");

endmodule

// ===== rtl/core/tlbat_ram.sv =====
// ----------------------------------------------------------------------------
// tlbat_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module tlbat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/tlbat_dp.sv =====
// ----------------------------------------------------------------------------
// tlbat_dp
// Datapath: configuration registers, entry RAM with valid bits, scan counter,
// match and permission check, result and output registers.
// ----------------------------------------------------------------------------
module tlbat_dp #(
  parameter int TLB_DEPTH = 16,
  parameter int PAGE_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tlbat_pkg::ctrl_cmd_t          cmd,
  output tlbat_pkg::dp_stat_t           stat,
  input  logic [tlbat_pkg::WORD_W-1:0]  in_vaddr,
  input  logic                          in_is_write,
  input  logic                          in_is_execute,
  input  logic [tlbat_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [tlbat_pkg::WORD_W-1:0]  in_entry_hi,
  input  logic [tlbat_pkg::WORD_W-1:0]  in_entry_lo,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [tlbat_pkg::CFG_W-1:0]   cfg_data,
  output logic [1:0]                    out_status,
  output logic [tlbat_pkg::WORD_W-1:0]  out_paddr
);

  localparam int AW  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CW  = AW + 1;
  localparam int WW  = tlbat_pkg::WORD_W;

  // Configuration registers.
  logic                          vm_enable_r;
  logic                          privileged_r;
  logic [tlbat_pkg::ASID_W-1:0]  asid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_enable_r  <= 1'b0;
      privileged_r <= 1'b1;
      asid_r       <= '0;
    end else if (cfg_valid) begin
      case (tlbat_pkg::cfg_idx_t'(cfg_index))
        tlbat_pkg::CFG_VM_ENABLE:    vm_enable_r  <= cfg_data[0];
        tlbat_pkg::CFG_PRIVILEGED:   privileged_r <= cfg_data[0];
        tlbat_pkg::CFG_CURRENT_ASID: asid_r       <= cfg_data[tlbat_pkg::ASID_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured item.
  logic [WW-1:0] vaddr_r;
  logic          is_write_r;
  logic          is_execute_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      vaddr_r      <= in_vaddr;
      is_write_r   <= in_is_write;
      is_execute_r <= in_is_execute;
    end
  end

  // Entry store: {hi, lo} per slot, valid bits cleared at reset.
  logic              idx_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [2*WW-1:0]   ram_rdata;
  logic [TLB_DEPTH-1:0] valid_r;
  logic [CW-1:0]     cnt_r;
  logic [AW-1:0]     cnt_idx;
  logic              pend_r;
  logic              pvalid_r;
  logic [AW-1:0]     pidx_r;

  assign idx_ok    = (32'(in_entry_index) < TLB_DEPTH);
  assign ram_we    = cmd.ram_we && idx_ok;
  assign ram_waddr = AW'(in_entry_index);
  assign cnt_idx   = cnt_r[AW-1:0];

  tlbat_ram #(
    .WIDTH (2*WW),
    .DEPTH (TLB_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_entry_hi, in_entry_lo}),
    .re    (cmd.issue),
    .raddr (cnt_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  // Scan counter and read tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.capture) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.issue;
      if (cmd.issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pidx_r   <= cnt_idx;
      pvalid_r <= valid_r[cnt_idx];
    end
  end

  // Match and permission check on the entry read last cycle.
  logic [WW-1:0] hi_w;
  logic [WW-1:0] lo_w;
  logic          hit;
  logic          fault;
  logic [WW-1:0] hit_paddr;

  assign hi_w = ram_rdata[2*WW-1:WW];
  assign lo_w = ram_rdata[WW-1:0];

  assign hit = pvalid_r && hi_w[tlbat_pkg::HI_VALID_BIT]
            && (hi_w[WW-1:PAGE_BITS] == vaddr_r[WW-1:PAGE_BITS])
            && (hi_w[tlbat_pkg::HI_ASID_MSB:tlbat_pkg::HI_ASID_LSB] == asid_r);

  assign fault = (!is_write_r && !is_execute_r && !privileged_r
                  && !lo_w[tlbat_pkg::LO_U_BIT])
              || (is_write_r && !lo_w[tlbat_pkg::LO_W_BIT]);

  assign hit_paddr = {lo_w[WW-1:PAGE_BITS], vaddr_r[PAGE_BITS-1:0]};

  assign stat.vm_enable = vm_enable_r;
  assign stat.pend      = pend_r;
  assign stat.hit       = hit;
  assign stat.last      = (pidx_r == AW'(TLB_DEPTH - 1));
  assign stat.cnt_end   = (cnt_r == CW'(TLB_DEPTH));

  // Result register, then output register.
  logic [1:0]    res_status_r;
  logic [WW-1:0] res_paddr_r;
  logic [1:0]    out_status_r;
  logic [WW-1:0] out_paddr_r;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      case (cmd.res_sel)
        tlbat_pkg::RES_WRITE: begin
          res_status_r <= tlbat_pkg::ST_OK;
          res_paddr_r  <= '0;
        end
        tlbat_pkg::RES_PASS: begin
          res_status_r <= tlbat_pkg::ST_OK;
          res_paddr_r  <= in_vaddr;
        end
        tlbat_pkg::RES_HIT: begin
          res_status_r <= fault ? tlbat_pkg::ST_FAULT : tlbat_pkg::ST_OK;
          res_paddr_r  <= fault ? '0 : hit_paddr;
        end
        default: begin
          res_status_r <= tlbat_pkg::ST_MISS;
          res_paddr_r  <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_paddr_r  <= res_paddr_r;
    end
  end

  assign out_status = out_status_r;
  assign out_paddr  = out_paddr_r;

endmodule

// ===== rtl/core/tlbat_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlbat_ctrl
// Controller: accepts items, sequences the entry scan and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module tlbat_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_kind,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlbat_pkg::ctrl_cmd_t  cmd,
  input  tlbat_pkg::dp_stat_t   stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;
  logic   out_free;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.res_sel   = tlbat_pkg::RES_WRITE;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.capture = 1'b1;
          if (in_kind) begin
            cmd.ram_we   = 1'b1;
            cmd.res_load = 1'b1;
            cmd.res_sel  = tlbat_pkg::RES_WRITE;
            state_nxt    = S_DONE;
          end else if (!stat.vm_enable) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = tlbat_pkg::RES_PASS;
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.pend && stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tlbat_pkg::RES_HIT;
          state_nxt    = S_DONE;
        end else if (stat.pend && stat.last) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = tlbat_pkg::RES_MISS;
          state_nxt    = S_DONE;
        end else begin
          cmd.issue = !stat.cnt_end;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // An accepted item always drops the input ready in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ready)
    else $error("input ready directly after an accepted beat");

  // Pass-through and entry writes need no scan.
  a_no_scan_needed: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_kind || !stat.vm_enable)) |=> (state_r == S_DONE))
    else $error("scan entered for an item that needs none");

  // A result is handed over only when the output register can take it.
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register overwritten while full");

endmodule
